/* rtl/core/sha512_stream_hasher_macros.svh */
// Assertion macros used by the hasher top level
`ifndef SHA512_STREAM_HASHER_MACROS_SVH
`define SHA512_STREAM_HASHER_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define SHA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sha512_pkg.sv */
`default_nettype none
package sha512_pkg;

    localparam int BlockBytes  = 128;
    localparam int LenOffset   = 112;
    localparam int Rounds      = 80;
    localparam int DigestWords = 8;
    localparam logic [7:0] PadByte = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic       wr_byte;
        logic [6:0] wr_addr;
        logic [7:0] wr_data;
        logic       len_inc;
        logic       len_clear;
        logic       comp_start;
        logic       chain_reset;
        logic [2:0] out_sel;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic comp_busy;
        logic comp_done;
    } dp_stat_t;

    function automatic logic [63:0] round_k(input logic [6:0] i);
        logic [63:0] k;
        begin
            case (i)
                7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
                7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
                7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
                7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
                7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
                7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
                7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
                7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
                7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
                7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
                7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
                7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
                7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
                7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
                7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
                7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
                7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
                7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
                7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
                7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
                7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
                7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
                7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
                7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
                7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
                7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
                7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
                7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
                7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
                7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
                7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
                7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
                7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
                7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
                7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
                7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
                7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
                7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
                7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
                7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
                default: k = 64'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [63:0] init_h(input logic [2:0] i);
        logic [63:0] h;
        begin
            case (i)
                3'd0: h = 64'h6a09e667f3bcc908;
                3'd1: h = 64'hbb67ae8584caa73b;
                3'd2: h = 64'h3c6ef372fe94f82b;
                3'd3: h = 64'ha54ff53a5f1d36f1;
                3'd4: h = 64'h510e527fade682d1;
                3'd5: h = 64'h9b05688c2b3e6c1f;
                3'd6: h = 64'h1f83d9abfb41bd6b;
                default: h = 64'h5be0cd19137e2179;
            endcase
            return h;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/sha512_stream_hasher.sv */
`default_nettype none
// Channel | Ports                                                 | Direction
// s_      | s_valid s_ready s_msg_byte s_byte_valid s_end_of_message | item in
// m_      | m_valid m_ready m_digest_word m_word_index m_last_word   | digest out
// A byte item is taken while idle; the 128th byte of a block starts the
// shared round unit (80 rounds, one per cycle) and input is held off while it runs.
// End of message: zero fill one byte per cycle up to the length field (a pad
// byte past it fills to block end, compresses, then fills 112 more), one or
// two compressions, then eight digest items. Input is held off meanwhile.
// Reset (aresetn low, synchronous) restores the initial hash values.
// A stalled m_ready holds the current digest word.
`include "sha512_stream_hasher_macros.svh"
module sha512_stream_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_msg_byte,
    input  wire logic        s_byte_valid,
    input  wire logic        s_end_of_message,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word
);

    sha512_pkg::dp_cmd_t  cmd;
    sha512_pkg::dp_stat_t stat;

    sha512_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_msg_byte       (s_msg_byte),
        .s_byte_valid     (s_byte_valid),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_word_index     (m_word_index),
        .m_last_word      (m_last_word),
        .cmd              (cmd),
        .stat             (stat)
    );

    sha512_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .digest_word (m_digest_word)
    );

    `SHA_ASSERT_IMP(a_no_in_while_out, aclk, aresetn, m_valid, !s_ready, "input open during digest")
    `SHA_ASSERT_IMP(a_no_out_while_busy, aclk, aresetn, stat.comp_busy, !m_valid, "digest during rounds")
    `SHA_ASSERT_NEXT(a_start_busy, aclk, aresetn, cmd.comp_start, stat.comp_busy, "round unit not started")

endmodule
`default_nettype wire

/* rtl/core/sha512_datapath.sv */
`default_nettype none
module sha512_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sha512_pkg::dp_cmd_t cmd,
    output sha512_pkg::dp_stat_t     stat,
    output logic [63:0]              digest_word
);

    // Block buffer held as sixteen 64-bit big-endian words
    logic [63:0] buf_reg [16];
    logic [63:0] w_reg [16];
    logic [63:0] h_reg [8];
    logic [63:0] v_reg [8];
    logic [63:0] len_reg;
    logic [6:0]  rnd_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] ld_w [16];

    logic [63:0] s0, s1, w_new, t1, t2, e, a, ch, maj, bits;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    assign bits = {len_reg[60:0], 3'b000};

    // Schedule and round logic
    always_comb begin
        s0    = rotr(w_reg[1], 1) ^ rotr(w_reg[1], 8) ^ (w_reg[1] >> 7);
        s1    = rotr(w_reg[14], 19) ^ rotr(w_reg[14], 61) ^ (w_reg[14] >> 6);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        e     = v_reg[4];
        a     = v_reg[0];
        ch    = (e & v_reg[5]) ^ (~e & v_reg[6]);
        maj   = (a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ch
              + sha512_pkg::round_k(rnd_reg) + w_reg[0];
        t2    = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + maj;
    end

    // Load words: buffer merged with the byte written this cycle, length
    // field in place when the controller has padded the block
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            ld_w[i] = buf_reg[i];
        end
        if (cmd.wr_byte) begin
            for (int b = 0; b < 8; b++) begin
                if (cmd.wr_addr[2:0] == 3'(b)) begin
                    ld_w[cmd.wr_addr[6:3]][63 - 8*b -: 8] = cmd.wr_data;
                end
            end
        end
        if (cmd.len_clear) begin
            ld_w[14] = '0;
            ld_w[15] = bits;
        end
    end

    // Write bytes into the buffer word lanes
    always_ff @(posedge aclk) begin
        if (cmd.wr_byte) begin
            for (int b = 0; b < 8; b++) begin
                if (cmd.wr_addr[2:0] == 3'(b)) begin
                    buf_reg[cmd.wr_addr[6:3]][63 - 8*b -: 8] <= cmd.wr_data;
                end
            end
        end
    end

    // Byte length
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.len_clear) begin
            len_reg <= '0;
        end else if (cmd.len_inc) begin
            len_reg <= len_reg + 64'd1;
        end
    end

    // Compression engine: one round per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.comp_start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end else if (busy_reg) begin
                if (rnd_reg == 7'(sha512_pkg::Rounds - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                rnd_reg <= rnd_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.comp_start) begin
            for (int i = 0; i < 16; i++) begin
                w_reg[i] <= ld_w[i];
            end
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (busy_reg) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // Chaining words
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.chain_reset) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha512_pkg::init_h(3'(i));
            end
        end else if (done_reg) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    assign digest_word    = h_reg[cmd.out_sel];
    assign stat.comp_busy = busy_reg;
    assign stat.comp_done = done_reg;

endmodule
`default_nettype wire

/* rtl/core/sha512_ctrl.sv */
`default_nettype none
module sha512_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_msg_byte,
    input  wire logic                 s_byte_valid,
    input  wire logic                 s_end_of_message,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [2:0]                m_word_index,
    output logic                      m_last_word,
    output sha512_pkg::dp_cmd_t       cmd,
    input  wire sha512_pkg::dp_stat_t stat
);

    sha512_pkg::state_t state_reg, state_next;
    logic [7:0] fill_reg, fill_next;
    logic       fin_reg, fin_next;    // finalising: padding still to do
    logic       pad_reg, pad_next;    // pad byte still to be written
    logic       last_reg, last_next;  // compression running holds the length
    logic [2:0] idx_reg, idx_next;
    logic       acc, out_acc;

    assign acc     = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        fin_next   = fin_reg;
        pad_next   = pad_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            sha512_pkg::ST_IDLE: begin
                if (acc) begin
                    if (s_byte_valid) begin
                        fill_next = fill_reg + 8'd1;
                    end
                    if (s_byte_valid && fill_reg == 8'(sha512_pkg::BlockBytes - 1)) begin
                        fill_next  = '0;
                        fin_next   = s_end_of_message;
                        pad_next   = s_end_of_message;
                        last_next  = 1'b0;
                        state_next = sha512_pkg::ST_COMP;
                    end else if (s_end_of_message) begin
                        fin_next   = 1'b1;
                        pad_next   = 1'b1;
                        state_next = sha512_pkg::ST_PAD;
                    end
                end
            end
            sha512_pkg::ST_PAD: begin
                // One padding byte per cycle up to the end or the length field
                fill_next = fill_reg + 8'd1;
                pad_next  = 1'b0;
                if (fill_reg == 8'(sha512_pkg::BlockBytes - 1)) begin
                    fill_next  = '0;
                    last_next  = 1'b0;
                    state_next = sha512_pkg::ST_COMP;
                end else if (fill_reg == 8'(sha512_pkg::LenOffset - 1)) begin
                    fill_next  = '0;
                    last_next  = 1'b1;
                    state_next = sha512_pkg::ST_COMP;
                end
            end
            sha512_pkg::ST_COMP: begin
                if (stat.comp_done) begin
                    if (last_reg) begin
                        idx_next   = '0;
                        state_next = sha512_pkg::ST_OUT;
                    end else if (fin_reg) begin
                        state_next = sha512_pkg::ST_PAD;
                    end else begin
                        state_next = sha512_pkg::ST_IDLE;
                    end
                end
            end
            sha512_pkg::ST_OUT: begin
                if (out_acc) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'(sha512_pkg::DigestWords - 1)) begin
                        fin_next   = 1'b0;
                        pad_next   = 1'b0;
                        last_next  = 1'b0;
                        fill_next  = '0;
                        state_next = sha512_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = sha512_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands and handshake outputs
    always_comb begin
        cmd          = '0;
        s_ready      = (state_reg == sha512_pkg::ST_IDLE);
        m_valid      = (state_reg == sha512_pkg::ST_OUT);
        m_word_index = idx_reg;
        m_last_word  = (idx_reg == 3'(sha512_pkg::DigestWords - 1));
        cmd.out_sel  = idx_reg;
        unique case (state_reg)
            sha512_pkg::ST_IDLE: begin
                cmd.wr_addr = fill_reg[6:0];
                if (acc && s_byte_valid) begin
                    cmd.wr_byte = 1'b1;
                    cmd.wr_data = s_msg_byte;
                    cmd.len_inc = 1'b1;
                    cmd.comp_start = (fill_reg == 8'(sha512_pkg::BlockBytes - 1));
                end
            end
            sha512_pkg::ST_PAD: begin
                cmd.wr_byte = 1'b1;
                cmd.wr_addr = fill_reg[6:0];
                cmd.wr_data = pad_reg ? sha512_pkg::PadByte : 8'h00;
                if (fill_reg == 8'(sha512_pkg::BlockBytes - 1)) begin
                    cmd.comp_start = 1'b1;
                end else if (fill_reg == 8'(sha512_pkg::LenOffset - 1)) begin
                    cmd.comp_start = 1'b1;
                    cmd.len_clear  = 1'b1;
                end
            end
            sha512_pkg::ST_COMP: begin
            end
            sha512_pkg::ST_OUT: begin
                cmd.chain_reset = out_acc && (idx_reg == 3'(sha512_pkg::DigestWords - 1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha512_pkg::ST_IDLE;
            fill_reg  <= '0;
            fin_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            last_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            fin_reg   <= fin_next;
            pad_reg   <= pad_next;
            last_reg  <= last_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
`default_nettype wire
